// ===== hdl/ofdm_symbol_bit_packer_macros.svh =====
// Assertion macros shared by the packer RTL.
`ifndef OFDM_SYMBOL_BIT_PACKER_MACROS_SVH
`define OFDM_SYMBOL_BIT_PACKER_MACROS_SVH

`ifndef ASSERT_OFF
// check a property on every clock edge outside reset
`define OSBP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define OSBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OSBP_ASSERT(lbl, clk, rst, prop, msg)
`define OSBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/osbp_pkg.sv =====
`default_nettype none

package osbp_pkg;

  localparam int MAX_SYMBOL_BITS = 8192;

  localparam int CFG_W     = 14;
  localparam int CW_W      = 32;
  localparam int WORD_W    = 32;
  localparam int BIT_IDX_W = $clog2(CW_W);
  localparam int FILL_W    = $clog2(WORD_W);
  localparam int REM_W     = $clog2(WORD_W);
  localparam int EFF_W     = $clog2(MAX_SYMBOL_BITS + 1);
  localparam int WORDS_W   = $clog2(MAX_SYMBOL_BITS / WORD_W + 2);

  localparam logic [CFG_W-1:0] BPS_RESET = CFG_W'(1024);

  // input queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [CW_W-1:0] codeword;
    logic            last_codeword;
  } cw_item_t;

  // head of the input queue as seen by the packer
  typedef struct packed {
    logic     valid;
    cw_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

// ===== hdl/osbp_cw_if.sv =====
`default_nettype none

interface osbp_cw_if;
  import osbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CW_W-1:0]   codeword;
  logic              last_codeword;

  modport source (output valid, output codeword, output last_codeword, input ready);
  modport sink   (input valid, input codeword, input last_codeword, output ready);
endinterface

`default_nettype wire

// ===== hdl/osbp_pk_if.sv =====
`default_nettype none

interface osbp_pk_if;
  import osbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_word;
  logic              symbol_end;
  logic              frame_flush;
  logic              last_of_run;

  modport source (output valid, output packed_word, output symbol_end,
                  output frame_flush, output last_of_run, input ready);
  modport sink   (input valid, input packed_word, input symbol_end,
                  input frame_flush, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/osbp_front.sv =====
`default_nettype none

`include "ofdm_symbol_bit_packer_macros.svh"

module osbp_front (
  input  wire                logic clk,
  input  wire                logic rst,
  osbp_cw_if.sink            cw_ch,
  output osbp_pkg::q_head_t  q_head,
  input  wire                logic q_pop
);
  import osbp_pkg::*;

  cw_item_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;

  assign cw_ch.ready = (count != Q_CNT_W'(Q_DEPTH));
  assign push        = cw_ch.valid && cw_ch.ready;

  assign q_head.valid = (count != '0);
  assign q_head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].codeword      <= cw_ch.codeword;
      slots[wr_ptr].last_codeword <= cw_ch.last_codeword;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `OSBP_ASSERT(a_pop_needs_item, clk, rst, q_pop |-> q_head.valid, "pop from empty queue")
  `OSBP_ASSERT(a_count_bound, clk, rst, count <= Q_CNT_W'(Q_DEPTH), "queue count overrun")
  `OSBP_ASSERT(a_full_blocks, clk, rst, (count == Q_CNT_W'(Q_DEPTH)) && !q_pop |=> !push || q_pop, "push into full queue")

endmodule

`default_nettype wire

// ===== hdl/osbp_back.sv =====
`default_nettype none

`include "ofdm_symbol_bit_packer_macros.svh"

module osbp_back (
  input  wire                       logic clk,
  input  wire                       logic rst,
  input  wire                       logic cfg_we,
  input  wire                       logic [osbp_pkg::CFG_W-1:0] cfg_data,
  input  osbp_pkg::q_head_t         q_head,
  output logic                      q_pop,
  osbp_pk_if.source                 pk_ch
);
  import osbp_pkg::*;

  // registers
  logic [CFG_W-1:0]     bps;
  logic [WORD_W-1:0]    acc;
  logic [FILL_W-1:0]    fill;
  logic [WORDS_W-1:0]   wis;
  logic [BIT_IDX_W-1:0] idx;
  logic                 out_valid;
  logic [WORD_W-1:0]    out_word;
  logic                 out_sym_end;
  logic                 out_flush;
  logic                 out_last;

  // derived symbol geometry
  logic [EFF_W-1:0]     eff;
  logic [REM_W-1:0]     rem;
  logic [WORDS_W-1:0]   words;

  // bit step
  logic                 bit_v;
  logic [WORD_W-1:0]    acc_set;
  logic [FILL_W:0]      fill_inc;
  logic                 in_last;
  logic                 full;
  logic                 short_end;
  logic                 word_emit;
  logic                 end_item;
  logic                 item_last;
  logic                 flush;
  logic                 emit;
  logic [WORDS_W-1:0]   wis_next;
  logic                 next_in_last;
  logic [FILL_W:0]      need_next;
  logic                 last_run;
  logic                 out_free;
  logic                 step;

  always_comb begin
    if (bps == '0) begin
      eff = EFF_W'(1);
    end else if (32'(bps) > 32'(MAX_SYMBOL_BITS)) begin
      eff = EFF_W'(MAX_SYMBOL_BITS);
    end else begin
      eff = EFF_W'(bps);
    end
    rem   = eff[REM_W-1:0];
    words = WORDS_W'(eff >> REM_W) + WORDS_W'(rem != '0);
  end

  always_comb begin
    bit_v     = q_head.item.codeword[idx];
    item_last = q_head.item.last_codeword;
    acc_set   = acc;
    acc_set[~fill] = bit_v;
    fill_inc  = {1'b0, fill} + 1'b1;

    in_last   = ({1'b0, wis} + 1'b1) >= {1'b0, words};
    full      = (fill_inc == (FILL_W + 1)'(WORD_W));
    short_end = in_last && (rem != '0) && (fill_inc == {1'b0, rem});
    word_emit = full || short_end;
    end_item  = (idx == '0);
    // a partial word left at frame end goes out as a flush word
    flush     = end_item && item_last && !word_emit;
    emit      = word_emit || flush;

    if (word_emit) begin
      wis_next = in_last ? '0 : wis + 1'b1;
    end else begin
      wis_next = wis;
    end

    // bits needed before the next word would close
    next_in_last = ({1'b0, wis_next} + 1'b1) >= {1'b0, words};
    need_next    = (next_in_last && (rem != '0)) ? {1'b0, rem} : (FILL_W + 1)'(WORD_W);
    last_run     = flush ||
                   (!(item_last && !end_item) && ({1'b0, idx} < need_next));

    out_free = !out_valid || pk_ch.ready;
    step     = q_head.valid && !(emit && !out_free);
    q_pop    = step && end_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bps       <= BPS_RESET;
      acc       <= '0;
      fill      <= '0;
      wis       <= '0;
      idx       <= BIT_IDX_W'(CW_W - 1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        bps <= cfg_data;
      end
      if (step) begin
        idx <= idx - 1'b1;
        if (emit) begin
          acc  <= '0;
          fill <= '0;
        end else begin
          acc  <= acc_set;
          fill <= fill_inc[FILL_W-1:0];
        end
        wis <= (end_item && item_last) ? '0 : wis_next;
      end
      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (pk_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_word    <= acc_set;
      out_sym_end <= word_emit && in_last;
      out_flush   <= flush;
      out_last    <= last_run;
    end
  end

  assign pk_ch.valid       = out_valid;
  assign pk_ch.packed_word = out_word;
  assign pk_ch.symbol_end  = out_sym_end;
  assign pk_ch.frame_flush = out_flush;
  assign pk_ch.last_of_run = out_last;

  `OSBP_ASSERT(a_pop_on_last_bit, clk, rst, q_pop |-> idx == '0, "item popped before last bit")
  `OSBP_ASSERT(a_flush_closes_run, clk, rst, out_valid && out_flush |-> out_last && !out_sym_end, "flush word flags wrong")
  `OSBP_ASSERT(a_frame_end_clear, clk, rst, q_pop && item_last |=> fill == '0 && wis == '0, "state left after frame end")
  `OSBP_ASSERT(a_no_overwrite, clk, rst, out_valid && !pk_ch.ready |=> $stable(out_word), "held word overwritten")

endmodule

`default_nettype wire

// ===== hdl/ofdm_symbol_bit_packer.sv =====
// OFDM symbol bit packer. Codewords (bit 31 first) are packed one bit per
// clock into 32-bit words that go out left-aligned, except that the packer
// stalls while a new word is ready and the sink still holds the last one.
// The output stream is cut into symbols of bits_per_symbol bits: whole
// words, then a final word holding the (bits mod 32) leftover bits,
// zero-padded, with symbol_end set on the word that closes each symbol. A
// codeword with last_codeword set flushes any partial word (frame_flush
// set, symbol_end clear) and restarts at the top of a symbol. last_of_run
// marks the final word caused by a given codeword. The packer is
// bit-serial. A two-beat input queue holds the codeword being packed and
// takes the next one while the packer works and while a finished word
// waits downstream. Write bits_per_symbol (0 reads as 1, values above 8192
// read as 8192) only when the block is idle.
`default_nettype none

module ofdm_symbol_bit_packer (
  input  wire           logic clk,
  input  wire           logic rst,
  osbp_cw_if.sink       cw_ch,
  osbp_pk_if.source     pk_ch,
  input  wire           logic cfg_we,
  input  wire           logic [osbp_pkg::CFG_W-1:0] cfg_data
);
  import osbp_pkg::*;

  // queue head and pop between the two halves
  q_head_t q_head;
  logic    q_pop;

  // front: takes codeword beats into the queue
  osbp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cw_ch  (cw_ch),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // back: bit-serial packer, symbol tracking and output register
  osbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .pk_ch    (pk_ch)
  );

endmodule

`default_nettype wire

// ===== verif/osbp_pack_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts every packed word
// and compares it with what comes out.
module osbp_pack_checker
  import osbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  osbp_cw_if                   cw_mon,
  osbp_pk_if                   pk_mon,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_data,
  output int unsigned          mismatch_cnt,
  output int unsigned          beats_due
);

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              symbol_end;
    logic              frame_flush;
    logic              last_of_run;
  } packed_beat_t;

  packed_beat_t words_due[$];

  // shadow of the packer
  logic [CFG_W-1:0]  bps;
  logic [WORD_W-1:0] acc_word;
  int unsigned       fill_cnt;
  int unsigned       word_idx;

  // last predicted word of the current codeword, held back to mark it
  packed_beat_t      held;
  logic              held_valid;

  packed_beat_t      got;
  packed_beat_t      want;

  initial begin
    mismatch_cnt = 0;
    beats_due    = 0;
  end

  task automatic stage_beat(input logic [WORD_W-1:0] w, input logic se, input logic ff);
    if (held_valid) words_due.push_back(held);
    held = '{packed_word: w, symbol_end: se, frame_flush: ff, last_of_run: 1'b0};
    held_valid = 1'b1;
  endtask

  task automatic pack_codeword(input logic [CW_W-1:0] cw, input logic last);
    int unsigned eff;
    int unsigned rem;
    int unsigned words;
    int          i;
    logic        in_last;
    eff = bps;
    if (eff == 0) eff = 1;
    if (eff > MAX_SYMBOL_BITS) eff = MAX_SYMBOL_BITS;
    rem   = eff & 31;
    words = (eff >> 5) + ((rem != 0) ? 1 : 0);
    held_valid = 1'b0;
    for (i = CW_W - 1; i >= 0; i--) begin
      in_last = (word_idx + 1 >= words);
      acc_word[WORD_W-1-fill_cnt] = cw[i];
      fill_cnt++;
      if (fill_cnt == WORD_W) begin
        stage_beat(acc_word, in_last, 1'b0);
        word_idx = in_last ? 0 : word_idx + 1;
        acc_word = '0;
        fill_cnt = 0;
      end else if (in_last && rem != 0 && fill_cnt == rem) begin
        // short closing word of the symbol
        stage_beat(acc_word, 1'b1, 1'b0);
        word_idx = 0;
        acc_word = '0;
        fill_cnt = 0;
      end
    end
    if (last) begin
      if (fill_cnt != 0) stage_beat(acc_word, 1'b0, 1'b1);
      acc_word = '0;
      fill_cnt = 0;
      word_idx = 0;
    end
    if (held_valid) begin
      held.last_of_run = 1'b1;
      words_due.push_back(held);
      held_valid = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bps      = BPS_RESET;
      acc_word = '0;
      fill_cnt = 0;
      word_idx = 0;
      words_due.delete();
    end else begin
      if (cfg_we) bps = cfg_data;
      if (cw_mon.valid && cw_mon.ready) pack_codeword(cw_mon.codeword, cw_mon.last_codeword);
      if (pk_mon.valid && pk_mon.ready) begin
        got = '{packed_word: pk_mon.packed_word, symbol_end: pk_mon.symbol_end,
                frame_flush: pk_mon.frame_flush, last_of_run: pk_mon.last_of_run};
        if (words_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got word %h end %b flush %b last %b",
                   $time, got.packed_word, got.symbol_end, got.frame_flush, got.last_of_run);
          mismatch_cnt++;
        end else begin
          want = words_due.pop_front();
          if (want !== got) begin
            $display("%0t: expected word %h end %b flush %b last %b, got word %h end %b flush %b last %b",
                     $time, want.packed_word, want.symbol_end, want.frame_flush,
                     want.last_of_run, got.packed_word, got.symbol_end, got.frame_flush,
                     got.last_of_run);
            mismatch_cnt++;
          end
        end
      end
    end
    beats_due = words_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the symbol bit packer. All word checking lives in
// the checker instance; this module drives reset, codewords, the sink's ready
// and the bits_per_symbol register, and runs a hang watchdog.
module tb_top;
  import osbp_pkg::*;

  // cycles to let the packer finish codewords that yield no words: the
  // two-deep queue, head being packed included, holds two codewords, with
  // margin
  localparam int SETTLE_CYCLES = 160;
  // cycles without any accepted beat before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 14;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  int unsigned mismatch_cnt;
  int unsigned beats_due;

  // idle chances in percent, changed per phase
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;

  int unsigned quiet_cycles = 0;

  osbp_cw_if cw_ch ();
  osbp_pk_if pk_ch ();

  ofdm_symbol_bit_packer i_dut (
    .clk      (clk),
    .rst      (rst),
    .cw_ch    (cw_ch),
    .pk_ch    (pk_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  osbp_pack_checker i_chk (
    .clk          (clk),
    .rst          (rst),
    .cw_mon       (cw_ch),
    .pk_mon       (pk_ch),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .mismatch_cnt (mismatch_cnt),
    .beats_due    (beats_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sink side: ready redrawn every edge, one assignment per edge
  initial begin
    pk_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      pk_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog: a long stretch with no beat on either side means a hang
  always @(posedge clk) begin
    if ((cw_ch.valid && cw_ch.ready) || (pk_ch.valid && pk_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d words still due", $time, beats_due);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // 0: no idling, 1: sender idle, 2: receiver stalling, 3: both lightly
  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      1: begin
        src_idle_pct  = 55;
        snk_stall_pct = 0;
      end
      2: begin
        src_idle_pct  = 0;
        snk_stall_pct = 55;
      end
      default: begin
        src_idle_pct  = 10;
        snk_stall_pct = 10;
      end
    endcase
  endtask

  // Offer one codeword and hold it until the beat is taken. Called, and
  // returns, on a rising edge; valid gets at most one assignment per edge.
  task automatic send_codeword(input logic [CW_W-1:0] cw, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      cw_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cw_ch.valid         <= 1'b1;
    cw_ch.codeword      <= cw;
    cw_ch.last_codeword <= last;
    @(posedge clk);
    while (!cw_ch.ready) @(posedge clk);
  endtask

  // Stop sending, wait for every predicted word, then let the packer finish
  // any codeword that yields nothing before the register may change.
  task automatic settle();
    cw_ch.valid <= 1'b0;
    do @(posedge clk); while (beats_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bps(input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [CW_W-1:0] rand_codeword();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  logic [CFG_W-1:0] phase_bps[RAND_PHASES];

  initial begin
    cw_ch.valid         <= 1'b0;
    cw_ch.codeword      <= '0;
    cw_ch.last_codeword <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_data            <= '0;
    rst                 <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // Reset length of 1024 bits: extremes of the codeword, and a frame that
    // ends exactly on a word boundary, so no flush word.
    set_idle(0);
    send_codeword(32'h0000_0000, 1'b0);
    send_codeword(32'hFFFF_FFFF, 1'b0);
    send_codeword(32'h8000_0000, 1'b0);
    send_codeword(32'h7FFF_FFFF, 1'b1);
    settle();

    // Zero is taken as one bit per symbol: every bit closes a symbol.
    write_bps('0);
    set_idle(2);
    send_codeword(32'hA5A5_A5A5, 1'b0);
    send_codeword(32'hFFFF_FFFF, 1'b1);
    settle();

    // All ones is clamped to the largest symbol; leave the frame open with
    // the word index well into the symbol.
    write_bps('1);
    set_idle(1);
    repeat (8) send_codeword($urandom(), 1'b0);
    settle();

    // Shrink the symbol mid-frame: the current word becomes the last word of
    // the symbol. Then run into a partial word and flush it at frame end.
    write_bps(CFG_W'(33));
    set_idle(3);
    send_codeword(32'hDEAD_BEEF, 1'b0);
    send_codeword(32'h1234_5678, 1'b0);
    send_codeword(32'h0F0F_0F0F, 1'b1);
    settle();

    // symbol of whole words only, then the exact maximum
    write_bps(CFG_W'(32));
    set_idle(0);
    send_codeword(32'hCAFE_F00D, 1'b1);
    settle();
    write_bps(CFG_W'(MAX_SYMBOL_BITS));
    send_codeword(32'h0000_0001, 1'b1);
    settle();

    // ---- random part ----
    // Frames end at random, so a phase often closes mid-frame and the next
    // length takes effect with the packer part-way through a symbol.
    phase_bps[0] = CFG_W'(1);
    phase_bps[1] = CFG_W'(MAX_SYMBOL_BITS);
    phase_bps[2] = CFG_W'(33);
    phase_bps[3] = CFG_W'(31);
    phase_bps[4] = '0;
    phase_bps[5] = '1;
    phase_bps[6] = CFG_W'($urandom_range(300, 2));
    phase_bps[7] = CFG_W'($urandom_range(16383));

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_bps(phase_bps[p]);
      set_idle(p % 4);
      repeat (PHASE_ITEMS) send_codeword(rand_codeword(), ($urandom_range(5) == 0));
      settle();
    end

    if (mismatch_cnt == 0 && beats_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/osbp_pkg.sv
hdl/osbp_cw_if.sv
hdl/osbp_pk_if.sv
hdl/osbp_front.sv
hdl/osbp_back.sv
hdl/ofdm_symbol_bit_packer.sv
verif/osbp_pack_checker.sv
verif/tb_top.sv
